/* sv/pts_pkg.sv */
// Shared types and constants for the priority task scheduler.
// Used by pts_ring_store and priority_task_scheduler; depends on nothing.
package pts_pkg;

	// Field widths fixed by the request and response formats
	localparam int unsigned ID_W        = 4;
	localparam int unsigned LVL_FIELD_W = 3;
	localparam int unsigned MAP_W       = 48;
	localparam int unsigned LIMIT_W     = 3;
	localparam int unsigned CFG_IDX_W   = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRIO_MAP    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 1'b1;

	// Reset values of the configuration registers
	localparam logic [MAP_W-1:0]   PRIO_MAP_RESET    = '0;
	localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RESET = 3'd4;

	// Request codes
	localparam logic [1:0] REQ_ACTIVATE  = 2'd0;
	localparam logic [1:0] REQ_TERMINATE = 2'd1;
	localparam logic [1:0] REQ_QUERY     = 2'd2;

	// Response status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_LIMIT   = 2'd1,
		ST_BAD_ID  = 2'd2,
		ST_NO_TERM = 2'd3
	} status_t;

	// Per-task scheduling state
	typedef enum logic [1:0] {
		TS_SUSPENDED = 2'd0,
		TS_READY     = 2'd1,
		TS_RUNNING   = 2'd2
	} task_state_t;

endpackage

/* sv/pts_ring_store.sv */
// Per-level FIFO rings of task ids with head, tail and fill count per level.
// Provides enqueue/dequeue status vectors and a look-ahead head read.
// Depends on pts_pkg.
module pts_ring_store #(
	parameter int unsigned NUM_LEVELS = 8,
	parameter int unsigned RING_DEPTH = 4,
	parameter int unsigned LVL_W      = 3,
	parameter int unsigned PTR_W      = 2,
	parameter int unsigned CNT_W      = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [CNT_W-1:0]           lim,
	input  logic                       enq_en,
	input  logic [LVL_W-1:0]           enq_level,
	input  logic [pts_pkg::ID_W-1:0]   enq_id,
	input  logic                       deq_en,
	input  logic [LVL_W-1:0]           deq_level,
	input  logic [LVL_W-1:0]           rd_level,
	output logic [NUM_LEVELS-1:0]      can_enq,
	output logic [NUM_LEVELS-1:0]      nonempty,
	output logic [NUM_LEVELS-1:0]      nonempty_nx,
	output logic [pts_pkg::ID_W-1:0]   rd_entry
);

	logic [pts_pkg::ID_W-1:0] entries_q [NUM_LEVELS][RING_DEPTH];
	logic [PTR_W-1:0]         head_q    [NUM_LEVELS];
	logic [PTR_W-1:0]         tail_q    [NUM_LEVELS];
	logic [CNT_W-1:0]         count_q   [NUM_LEVELS];
	logic [PTR_W-1:0]         head_nx   [NUM_LEVELS];
	logic [CNT_W-1:0]         count_nx  [NUM_LEVELS];
	logic [NUM_LEVELS-1:0]    enq_hit;
	logic [NUM_LEVELS-1:0]    deq_hit;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (32'(p) == RING_DEPTH - 1)
			return '0;
		return p + PTR_W'(1);
	endfunction

	// Per-level next pointers, counts and status flags
	always_comb begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			enq_hit[l]     = enq_en && (32'(enq_level) == l);
			deq_hit[l]     = deq_en && (32'(deq_level) == l);
			head_nx[l]     = deq_hit[l] ? ptr_inc(head_q[l]) : head_q[l];
			count_nx[l]    = count_q[l];
			if (enq_hit[l])
				count_nx[l] = count_q[l] + CNT_W'(1);
			else if (deq_hit[l])
				count_nx[l] = count_q[l] - CNT_W'(1);
			can_enq[l]     = count_q[l] < lim;
			nonempty[l]    = count_q[l] != '0;
			nonempty_nx[l] = count_nx[l] != '0;
		end
	end

	// Head of the selected level after this request; bypass a write into an empty ring
	always_comb begin
		if (enq_hit[rd_level] && count_q[rd_level] == '0)
			rd_entry = enq_id;
		else
			rd_entry = entries_q[rd_level][head_nx[rd_level]];
	end

	// Advance ring pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l]  <= head_nx[l];
				count_q[l] <= count_nx[l];
				if (enq_hit[l])
					tail_q[l] <= ptr_inc(tail_q[l]);
			end
		end
	end

	// Write the enqueued id at the tail slot
	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (enq_hit[l])
				entries_q[l][tail_q[l]] <= enq_id;
		end
	end

endmodule

/* sv/priority_task_scheduler.sv */
// Priority task scheduler: one FIFO ring per level, highest ready level runs.
// A request is captured in the input stage and then in the result register; both hold while a response waits.
// Throughput: one request per cycle while responses are taken; state update and level select happen in the same cycle.
// Reset clears ring pointers and counts, task states and running level; config to defaults.
// Ring slots are not cleared; only occupied slots are ever read.
module priority_task_scheduler #(
	parameter int unsigned NUM_TASKS  = 16,
	parameter int unsigned NUM_LEVELS = 8,
	parameter int unsigned RING_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration writes
	input  logic                            cfg_we,
	input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pts_pkg::MAP_W-1:0]       cfg_data,
	// Request channel
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [1:0]                      req_type,
	input  logic [pts_pkg::ID_W-1:0]        task_id,
	// Response channel
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [1:0]                      status,
	output logic [1:0]                      task_state,
	output logic [pts_pkg::ID_W-1:0]        current_task,
	output logic                            current_valid,
	output logic [pts_pkg::LVL_FIELD_W-1:0] current_level,
	output logic                            switch_needed
);

	localparam int unsigned LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);

	// Configuration registers
	logic [pts_pkg::MAP_W-1:0]   prio_map_q;
	logic [pts_pkg::LIMIT_W-1:0] queue_limit_q;

	// Input stage
	logic                        valid_s1;
	logic [1:0]                  req_s1;
	logic [pts_pkg::ID_W-1:0]    id_s1;

	// Scheduler state
	pts_pkg::task_state_t        tstate_q [NUM_TASKS];
	logic                        run_valid_q;
	logic [LVL_W-1:0]            run_level_q;
	logic [pts_pkg::ID_W-1:0]    cur_task_q;

	// Result register
	logic                        rsp_valid_q;
	pts_pkg::status_t            status_q;
	pts_pkg::task_state_t        tstate_out_q;
	logic [pts_pkg::ID_W-1:0]    cur_out_q;
	logic                        cur_valid_q;
	logic [LVL_W-1:0]            level_out_q;
	logic                        switch_q;

	// Datapath
	logic                        proceed;
	logic                        fire;
	logic                        id_ok;
	logic [pts_pkg::LVL_FIELD_W-1:0] raw_level;
	logic [LVL_W-1:0]            act_level;
	logic [CNT_W-1:0]            eff_lim;
	logic                        enq_en;
	logic                        deq_en;
	logic [NUM_LEVELS-1:0]       can_enq;
	logic [NUM_LEVELS-1:0]       nonempty;
	logic [NUM_LEVELS-1:0]       nonempty_nx;
	logic [pts_pkg::ID_W-1:0]    head_entry;
	logic                        sel_valid;
	logic [LVL_W-1:0]            sel_level;
	logic                        sw;
	logic                        demote;
	pts_pkg::status_t            status_nx;
	pts_pkg::task_state_t        query_state;
	pts_pkg::task_state_t        tstate_nx [NUM_TASKS];
	logic [NUM_TASKS-1:0]        running_flags;

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_map_q    <= pts_pkg::PRIO_MAP_RESET;
			queue_limit_q <= pts_pkg::QUEUE_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pts_pkg::CFG_PRIO_MAP:    prio_map_q    <= cfg_data;
				pts_pkg::CFG_QUEUE_LIMIT: queue_limit_q <= cfg_data[pts_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage drains whenever the result register can take a value
	assign proceed   = !rsp_valid_q || rsp_ready;
	assign fire      = valid_s1 && proceed;
	assign req_ready = !valid_s1 || proceed;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req_ready)
			valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_type;
			id_s1  <= task_id;
		end
	end

	// Level of the requested task and the effective ring limit
	always_comb begin
		id_ok     = 32'(id_s1) < NUM_TASKS;
		raw_level = prio_map_q[pts_pkg::LVL_FIELD_W * int'(id_s1) +: pts_pkg::LVL_FIELD_W];
		if (32'(raw_level) >= NUM_LEVELS)
			act_level = LVL_W'(NUM_LEVELS - 1);
		else
			act_level = LVL_W'(raw_level);
		if (32'(queue_limit_q) > RING_DEPTH)
			eff_lim = CNT_W'(RING_DEPTH);
		else
			eff_lim = CNT_W'(queue_limit_q);
	end

	// Decode the request into ring operations and a status
	always_comb begin
		enq_en    = 1'b0;
		deq_en    = 1'b0;
		status_nx = pts_pkg::ST_OK;
		case (req_s1)
			pts_pkg::REQ_ACTIVATE: begin
				if (!id_ok)
					status_nx = pts_pkg::ST_BAD_ID;
				else if (can_enq[act_level])
					enq_en = fire;
				else
					status_nx = pts_pkg::ST_LIMIT;
			end
			pts_pkg::REQ_TERMINATE: begin
				if (run_valid_q && nonempty[run_level_q])
					deq_en = fire;
				else
					status_nx = pts_pkg::ST_NO_TERM;
			end
			pts_pkg::REQ_QUERY: begin
				if (!id_ok)
					status_nx = pts_pkg::ST_BAD_ID;
			end
			default: ;
		endcase
	end

	pts_ring_store #(
		.NUM_LEVELS (NUM_LEVELS),
		.RING_DEPTH (RING_DEPTH),
		.LVL_W      (LVL_W),
		.PTR_W      (PTR_W),
		.CNT_W      (CNT_W)
	) u_rings (
		.clk         (clk),
		.arst_n      (arst_n),
		.lim         (eff_lim),
		.enq_en      (enq_en),
		.enq_level   (act_level),
		.enq_id      (id_s1),
		.deq_en      (deq_en),
		.deq_level   (run_level_q),
		.rd_level    (sel_level),
		.can_enq     (can_enq),
		.nonempty    (nonempty),
		.nonempty_nx (nonempty_nx),
		.rd_entry    (head_entry)
	);

	// Select the highest ready level after this request
	always_comb begin
		sel_valid = 1'b0;
		sel_level = '0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (nonempty_nx[l]) begin
				sel_valid = 1'b1;
				sel_level = LVL_W'(l);
			end
		end
		sw = (sel_valid != run_valid_q) || (sel_valid && sel_level != run_level_q);
	end

	// Query read of the task state before this request's update
	always_comb begin
		query_state = pts_pkg::TS_SUSPENDED;
		for (int t = 0; t < NUM_TASKS; t++) begin
			if (req_s1 == pts_pkg::REQ_QUERY && 32'(id_s1) == t)
				query_state = tstate_q[t];
		end
	end

	// Task state update: request effect, then preemption, then the new running head.
	// The running task is always the head of the running level, so it is the one
	// dequeued by a terminate and the one pushed back to ready on a level change.
	always_comb begin
		demote = 1'b0;
		for (int t = 0; t < NUM_TASKS; t++) begin
			tstate_nx[t] = tstate_q[t];
			if (enq_en && 32'(id_s1) == t && tstate_q[t] == pts_pkg::TS_SUSPENDED)
				tstate_nx[t] = pts_pkg::TS_READY;
			if (deq_en && 32'(cur_task_q) == t)
				tstate_nx[t] = pts_pkg::TS_SUSPENDED;
			if (sw && run_valid_q && nonempty_nx[run_level_q] && 32'(cur_task_q) == t
				&& tstate_nx[t] == pts_pkg::TS_RUNNING) begin
				tstate_nx[t] = pts_pkg::TS_READY;
				demote = 1'b1;
			end
			if (sel_valid && 32'(head_entry) == t)
				tstate_nx[t] = pts_pkg::TS_RUNNING;
		end
	end

	// Commit scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TASKS; t++)
				tstate_q[t] <= pts_pkg::TS_SUSPENDED;
			run_valid_q <= 1'b0;
			run_level_q <= '0;
			cur_task_q  <= '0;
		end else if (fire) begin
			for (int t = 0; t < NUM_TASKS; t++)
				tstate_q[t] <= tstate_nx[t];
			run_valid_q <= sel_valid;
			run_level_q <= sel_level;
			cur_task_q  <= sel_valid ? head_entry : '0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (fire)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q     <= status_nx;
			tstate_out_q <= (req_s1 == pts_pkg::REQ_QUERY && id_ok) ? query_state
				: pts_pkg::TS_SUSPENDED;
			cur_out_q    <= sel_valid ? head_entry : '0;
			cur_valid_q  <= sel_valid;
			level_out_q  <= sel_level;
			switch_q     <= sw;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign task_state    = tstate_out_q;
	assign current_task  = cur_out_q;
	assign current_valid = cur_valid_q;
	assign current_level = pts_pkg::LVL_FIELD_W'(level_out_q);
	assign switch_needed = switch_q;

	// Running flags for the checks below
	always_comb begin
		for (int t = 0; t < NUM_TASKS; t++)
			running_flags[t] = tstate_q[t] == pts_pkg::TS_RUNNING;
	end

	// The running level always holds at least one queued task
	a_run_level_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> nonempty[run_level_q])
		else $error("running level has an empty ring");

	// No running level means nothing is queued and no task is running
	a_idle_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!run_valid_q |-> (nonempty == '0 && running_flags == '0))
		else $error("no level running but rings or tasks are active");

	// At most one task runs at a time
	a_single_runner: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(running_flags) <= 1)
		else $error("more than one task running");

	// The tracked running task is the one marked running
	a_cur_task_running: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> running_flags[cur_task_q])
		else $error("tracked running task not in running state");

	// A preemption only happens on a level change
	a_demote_on_switch: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && demote) |-> (sw && run_valid_q))
		else $error("task preempted without a level switch");

endmodule
